@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// Depends on nothing; the including module must have aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define FWVF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked while the reset is asserted.
`define FWVF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/fwvf_pkg.sv @@
// Package of the force window velocity follower: widths, constants and shared types.
// Depends on nothing; used by every module of the block.
package fwvf_pkg;

    localparam int WINDOW    = 20;
    localparam int NUM_AXES  = 3;
    localparam int AXIS_X    = 0;
    localparam int AXIS_Y    = 1;
    localparam int AXIS_Z    = 2;

    localparam int IN_W      = 20;
    localparam int OUT_W     = 28;
    localparam int THR_W     = 19;
    localparam int GAIN_W    = 10;
    localparam int CFG_W     = 19;
    localparam int IDX_W     = 2;

    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int SUM_W     = IN_W + $clog2(WINDOW);
    localparam int MEAN_W    = IN_W;
    localparam int VEL_SHIFT = 8;
    localparam int DIVD_W    = MEAN_W + VEL_SHIFT;
    localparam int DIV_STEPS = DIVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int SQ_W      = 2 * MEAN_W - 1;
    localparam int MAG_W     = SQ_W + 2;
    localparam int THR2_W    = 2 * THR_W;
    localparam int LATENCY   = DIV_STEPS + 6;

    // floor(2^SUM_W / WINDOW); the truncated product is at most one below the true mean.
    localparam logic [SUM_W-1:0] MEAN_RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW);

    localparam logic [IDX_W-1:0] REG_FORCE_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_DIVISOR    = 2'd1;
    localparam logic [IDX_W-1:0] REG_TORQUE_LIMIT    = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET    = 19'd1280;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 10'd200;
    localparam logic [THR_W-1:0]  TORQUE_RESET = 19'd256;

    typedef struct packed {
        logic load;
        logic full;
        logic sum_en;
        logic mul_en;
        logic corr_en;
        logic sqr_en;
        logic div_en;
    } lane_ctrl_t;

endpackage

@@ hw/rtl/fwvf_lane.sv @@
// One axis lane: sample ring, running sum, mean, squared mean and radix-4 gain divider.
// Depends on fwvf_pkg.
module fwvf_lane import fwvf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lane_ctrl_t               ctrl,
    input  logic [SLOT_W-1:0]        slot,
    input  logic signed [IN_W-1:0]   force_in,
    input  logic [GAIN_W-1:0]        gain,
    output logic [SQ_W-1:0]          sq,
    output logic signed [OUT_W-1:0]  vel
);

    logic signed [IN_W-1:0]   win_mem [WINDOW];
    logic signed [IN_W-1:0]   old_reg;
    logic signed [IN_W-1:0]   new_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]         sum_abs;
    logic [SUM_W-1:0]         sum_abs_reg;
    logic                     sum_neg_reg;
    logic [2*SUM_W-1:0]       prod_reg;
    logic [SUM_W-1:0]         quot0;
    logic [SUM_W-1:0]         resid;
    logic [SUM_W-1:0]         mean_mag;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [MEAN_W-1:0]        mean_abs;
    logic [2*MEAN_W-1:0]      sq_full;
    logic [SQ_W-1:0]          sq_reg;
    logic [GAIN_W-1:0]        rem_reg;
    logic [GAIN_W-1:0]        rem_next;
    logic [DIVD_W-1:0]        quo_reg;
    logic [DIVD_W-1:0]        quo_next;
    logic                     vel_neg_reg;
    logic [GAIN_W:0]          part1;
    logic [GAIN_W:0]          part2;
    logic [GAIN_W:0]          gain_ext;
    logic                     bit1;
    logic                     bit0;

    // The old entry is read before the new sample overwrites it.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            old_reg       <= win_mem[slot];
            win_mem[slot] <= force_in;
            new_reg       <= force_in;
        end
    end

    assign sum_next = sum_reg + SUM_W'(new_reg) - (ctrl.full ? SUM_W'(old_reg) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.sum_en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quot0    = prod_reg[2*SUM_W-1:SUM_W];
    assign resid    = sum_abs_reg - SUM_W'(quot0 * SUM_W'(WINDOW));
    assign mean_mag = (resid >= SUM_W'(WINDOW)) ? quot0 + SUM_W'(1) : quot0;
    assign mean_abs = mean_reg[MEAN_W-1] ? MEAN_W'(-mean_reg) : MEAN_W'(mean_reg);
    assign sq_full  = mean_abs * mean_abs;

    // Two restoring steps per cycle on the shifted mean magnitude.
    assign gain_ext = {1'b0, gain};
    always_comb begin
        part1 = {rem_reg, quo_reg[DIVD_W-1]};
        bit1  = (part1 >= gain_ext);
        if (bit1) begin
            part1 = part1 - gain_ext;
        end
        part2 = {part1[GAIN_W-1:0], quo_reg[DIVD_W-2]};
        bit0  = (part2 >= gain_ext);
        if (bit0) begin
            part2 = part2 - gain_ext;
        end
        rem_next = part2[GAIN_W-1:0];
        quo_next = {quo_reg[DIVD_W-3:0], bit1, bit0};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            sum_abs_reg <= sum_abs;
            sum_neg_reg <= sum_reg[SUM_W-1];
            prod_reg    <= sum_abs * MEAN_RECIP;
        end
        if (ctrl.corr_en) begin
            mean_reg <= sum_neg_reg ? MEAN_W'(-mean_mag) : MEAN_W'(mean_mag);
        end
        if (ctrl.sqr_en) begin
            sq_reg      <= sq_full[SQ_W-1:0];
            quo_reg     <= {mean_abs, VEL_SHIFT'(0)};
            rem_reg     <= '0;
            vel_neg_reg <= mean_reg[MEAN_W-1];
        end else if (ctrl.div_en) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign sq  = sq_reg;
    assign vel = vel_neg_reg ? OUT_W'(-$signed(quo_reg)) : OUT_W'($signed(quo_reg));

endmodule

@@ hw/rtl/fwvf_merge.sv @@
// Merge stage: magnitude against deadband, axis sign handling, capture flag, output register.
// Depends on fwvf_pkg.
module fwvf_merge import fwvf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic [SQ_W-1:0]          sq [NUM_AXES],
    input  logic signed [OUT_W-1:0]  vel [NUM_AXES],
    input  logic signed [IN_W-1:0]   torque,
    input  logic [THR_W-1:0]         thr,
    input  logic [THR_W-1:0]         tlim,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic signed [OUT_W-1:0]  m_vel_x,
    output logic signed [OUT_W-1:0]  m_vel_y,
    output logic signed [OUT_W-1:0]  m_vel_z,
    output logic                     m_capture,
    output logic                     busy
);

    localparam logic signed [OUT_W-1:0] VEL_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] VEL_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    logic [MAG_W-1:0]         mag_reg;
    logic [THR2_W-1:0]        thr2_reg;
    logic                     pass;
    logic [IN_W-1:0]          tz_abs;
    logic signed [OUT_W-1:0]  vel_y_neg;
    logic signed [OUT_W-1:0]  vel_z_neg;
    logic                     m_valid_reg;
    logic signed [OUT_W-1:0]  vel_x_reg;
    logic signed [OUT_W-1:0]  vel_y_reg;
    logic signed [OUT_W-1:0]  vel_z_reg;
    logic                     capture_reg;

    always_ff @(posedge aclk) begin
        mag_reg  <= MAG_W'(sq[AXIS_X]) + MAG_W'(sq[AXIS_Y]) + MAG_W'(sq[AXIS_Z]);
        thr2_reg <= thr * thr;
    end

    assign pass      = mag_reg > MAG_W'(thr2_reg);
    assign tz_abs    = torque[IN_W-1] ? IN_W'(-torque) : IN_W'(torque);
    // Negating the most negative quotient saturates.
    assign vel_y_neg = (vel[AXIS_Y] == VEL_MIN) ? VEL_MAX : -vel[AXIS_Y];
    assign vel_z_neg = (vel[AXIS_Z] == VEL_MIN) ? VEL_MAX : -vel[AXIS_Z];

    always_ff @(posedge aclk) begin
        if (load) begin
            vel_x_reg   <= pass ? vel[AXIS_X] : '0;
            vel_y_reg   <= pass ? vel_y_neg : '0;
            vel_z_reg   <= pass ? vel_z_neg : '0;
            capture_reg <= tz_abs > IN_W'(tlim);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_vel_x   = vel_x_reg;
    assign m_vel_y   = vel_y_reg;
    assign m_vel_z   = vel_z_reg;
    assign m_capture = capture_reg;
    assign busy      = m_valid_reg && !m_ready;

endmodule

@@ hw/rtl/force_window_velocity_follower.sv @@
// Force window velocity follower: windowed mean force to velocity command with deadband.
// Depends on fwvf_pkg, fwvf_lane and fwvf_merge.
//
// The input channel (s_valid/s_ready) takes one force/torque sample per item. The
// result channel (m_valid/m_ready) gives one velocity item per input item, except
// for the first WINDOW items after reset, which only fill the sample ring.
// Registers are written through the cfg_valid/cfg_ready channel, which is ready
// whenever reset is released; they should only be changed while the block is idle.
// Three identical lanes handle x, y and z side by side; a merge stage compares the
// squared mean magnitude against the deadband and builds the result.
// After the accepting edge an item passes the SUM, MUL, CORR, SQR, DIV and OUT states
// before m_valid rises; the radix-4 gain divider in each lane (the DIV state) makes up
// most of this path. An item that fills the ring passes only the SUM state. A new
// item is accepted only once the previous one has left the lanes, so the block takes
// no new item while it is still working on one.
// A finished result waits in the output register while the next item is taken in;
// if the receiver stalls, the block holds the next result in the lanes until the
// output register is free.
// Reset (aresetn, synchronous, active low) clears the ring fill count, write slot,
// running sums and the output valid, and restores the register defaults. Neither
// the input nor the configuration channel is ready while reset is asserted.
module force_window_velocity_follower import fwvf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [IN_W-1:0]   s_force_x,
    input  logic signed [IN_W-1:0]   s_force_y,
    input  logic signed [IN_W-1:0]   s_force_z,
    input  logic signed [IN_W-1:0]   s_torque_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_vel_x,
    output logic signed [OUT_W-1:0]  m_vel_y,
    output logic signed [OUT_W-1:0]  m_vel_z,
    output logic                     m_capture,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    // One-hot sequencer that steps every lane through the same phases.
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SUM  = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_CORR = 7'b0001000,
        ST_SQR  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    full_reg;
    logic                    ring_full;
    logic                    s_accept;
    logic                    out_busy;
    logic                    out_load;
    logic signed [IN_W-1:0]  torque_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic [THR_W-1:0]        tlim_reg;
    logic [GAIN_W-1:0]       gain_eff;
    lane_ctrl_t              lane_ctrl;
    logic signed [IN_W-1:0]  force_in [NUM_AXES];
    logic [SQ_W-1:0]         lane_sq [NUM_AXES];
    logic signed [OUT_W-1:0] lane_vel [NUM_AXES];

    // Configuration registers. Writes beyond the register list are dropped.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_RESET;
            gain_reg <= GAIN_RESET;
            tlim_reg <= TORQUE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FORCE_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                REG_GAIN_DIVISOR:    gain_reg <= cfg_data[GAIN_W-1:0];
                REG_TORQUE_LIMIT:    tlim_reg <= cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A divisor of zero behaves as one.
    assign gain_eff = (gain_reg == '0) ? GAIN_W'(1) : gain_reg;

    assign s_ready   = aresetn && (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign ring_full = (fill_reg == FILL_W'(WINDOW));
    assign out_load  = (state_reg == ST_OUT) && !out_busy;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_SUM;
            ST_SUM:  state_next = full_reg ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_CORR;
            ST_CORR: state_next = ST_SQR;
            ST_SQR:  state_next = ST_DIV;
            ST_DIV:  if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_OUT;
            ST_OUT:  if (!out_busy) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            fill_reg    <= '0;
            slot_reg    <= '0;
            full_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SQR) begin
                div_cnt_reg <= '0;
            end else if (state_reg == ST_DIV) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (s_accept) begin
                full_reg <= ring_full;
                if (!ring_full) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
            end
        end
    end

    // The torque sample is only needed when the result is built.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            torque_reg <= s_torque_z;
        end
    end

    assign lane_ctrl.load    = s_accept;
    assign lane_ctrl.full    = full_reg;
    assign lane_ctrl.sum_en  = (state_reg == ST_SUM);
    assign lane_ctrl.mul_en  = (state_reg == ST_MUL);
    assign lane_ctrl.corr_en = (state_reg == ST_CORR);
    assign lane_ctrl.sqr_en  = (state_reg == ST_SQR);
    assign lane_ctrl.div_en  = (state_reg == ST_DIV);

    assign force_in[AXIS_X] = s_force_x;
    assign force_in[AXIS_Y] = s_force_y;
    assign force_in[AXIS_Z] = s_force_z;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        fwvf_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .slot     (slot_reg),
            .force_in (force_in[i]),
            .gain     (gain_eff),
            .sq       (lane_sq[i]),
            .vel      (lane_vel[i])
        );
    end

    fwvf_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .sq        (lane_sq),
        .vel       (lane_vel),
        .torque    (torque_reg),
        .thr       (thr_reg),
        .tlim      (tlim_reg),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_vel_x   (m_vel_x),
        .m_vel_y   (m_vel_y),
        .m_vel_z   (m_vel_z),
        .m_capture (m_capture),
        .busy      (out_busy)
    );

endmodule

@@ hw/rtl/fwvf_checker.sv @@
// Port-level checker for the force window velocity follower, bound to the top level.
// Depends on fwvf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fwvf_checker import fwvf_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [OUT_W-1:0]  m_vel_x,
    input logic signed [OUT_W-1:0]  m_vel_y,
    input logic signed [OUT_W-1:0]  m_vel_z,
    input logic                     m_capture
);

    // A stalled result keeps its valid and its payload.
    `FWVF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_vel_x) && $stable(m_vel_y) && $stable(m_vel_z) && $stable(m_capture), "result changed while stalled")

    // Reset empties the output register.
    `FWVF_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

    // A fresh result always comes from the most recently accepted item.
    `FWVF_ASSERT(a_latency, $rose(m_valid) |-> $past(s_valid && s_ready, LATENCY), "result without matching item")

    // The block works on one item at a time.
    `FWVF_ASSERT(a_one_item, s_valid && s_ready |=> !s_ready, "item accepted back to back")

endmodule

bind force_window_velocity_follower fwvf_checker u_fwvf_checker (.*);

@@ verif/tb_top.sv @@
// Testbench of force_window_velocity_follower: directed and random force samples are
// checked item by item against a windowed-mean velocity predictor kept in this file.
// Depends on fwvf_pkg and the force_window_velocity_follower RTL.
`timescale 1ns / 100ps

module tb_top;
    import fwvf_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int NUM_PHASES      = 8;
    localparam int FORCE_MAX       = (1 << (IN_W - 1)) - 1;
    localparam int FORCE_MIN       = -(1 << (IN_W - 1));
    localparam longint VEL_MAX     = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint VEL_MIN     = -(longint'(1) << (OUT_W - 1));
    localparam logic [CFG_W-1:0] CFG_MAX = '1;
    // The index port is two bits wide, so one index exists that maps to no register.
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    // One velocity item as it leaves the block.
    typedef struct packed {
        logic [OUT_W-1:0] vel_x;
        logic [OUT_W-1:0] vel_y;
        logic [OUT_W-1:0] vel_z;
        logic             capture;
    } velocity_cmd_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic signed [IN_W-1:0]  s_force_x  = '0;
    logic signed [IN_W-1:0]  s_force_y  = '0;
    logic signed [IN_W-1:0]  s_force_z  = '0;
    logic signed [IN_W-1:0]  s_torque_z = '0;
    logic                    m_valid;
    logic                    m_ready    = 1'b0;
    logic signed [OUT_W-1:0] m_vel_x;
    logic signed [OUT_W-1:0] m_vel_y;
    logic signed [OUT_W-1:0] m_vel_z;
    logic                    m_capture;
    logic                    cfg_valid  = 1'b0;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index  = '0;
    logic [CFG_W-1:0]        cfg_data   = '0;

    // Register values as the block should hold them.
    logic [THR_W-1:0]  threshold_reg = THR_RESET;
    logic [GAIN_W-1:0] gain_reg      = GAIN_RESET;
    logic [THR_W-1:0]  torque_reg    = TORQUE_RESET;

    // Sample ring and running sums of the predictor. An entry is only read after
    // it has been written, so the ring needs no reset value.
    logic signed [IN_W-1:0] ring_x [WINDOW];
    logic signed [IN_W-1:0] ring_y [WINDOW];
    logic signed [IN_W-1:0] ring_z [WINDOW];
    longint sum_x      = 0;
    longint sum_y      = 0;
    longint sum_z      = 0;
    int     fill_level = 0;
    int     write_slot = 0;

    velocity_cmd_t expected_velocities[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int stall_cycles   = 0;
    bit no_idle        = 1'b0;

    force_window_velocity_follower DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_force_x  (s_force_x),
        .s_force_y  (s_force_y),
        .s_force_z  (s_force_z),
        .s_torque_z (s_torque_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_vel_x    (m_vel_x),
        .m_vel_y    (m_vel_y),
        .m_vel_z    (m_vel_z),
        .m_capture  (m_capture),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Run limit. A correct run ends far below it even with every stall taken.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result receiver. A long hold-off requested by a test is counted down here;
    // otherwise ready drops at random unless the no-idle stretch is active.
    always @(posedge aclk) begin
        if (stall_cycles > 0) begin
            stall_cycles--;
            m_ready <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    function automatic longint clamp_velocity(input longint v);
        if (v > VEL_MAX) return VEL_MAX;
        if (v < VEL_MIN) return VEL_MIN;
        return v;
    endfunction

    // Updates the ring with one accepted sample and queues the velocity item that
    // it should cause. Samples that only fill the ring cause nothing.
    function automatic void predict_velocity(input logic signed [IN_W-1:0] fx, fy, fz, tz);
        longint        mean_x, mean_y, mean_z, mag2, thr2, gain, abs_torque;
        bit            full;
        velocity_cmd_t cmd;
        full = (fill_level >= WINDOW);
        if (full) begin
            sum_x -= ring_x[write_slot];
            sum_y -= ring_y[write_slot];
            sum_z -= ring_z[write_slot];
        end
        ring_x[write_slot] = fx;
        ring_y[write_slot] = fy;
        ring_z[write_slot] = fz;
        sum_x += fx;
        sum_y += fy;
        sum_z += fz;
        write_slot = (write_slot + 1) % WINDOW;
        if (!full) begin
            fill_level++;
            return;
        end
        // Division of signed values truncates toward zero, as the block does.
        mean_x = sum_x / WINDOW;
        mean_y = sum_y / WINDOW;
        mean_z = sum_z / WINDOW;
        mag2 = mean_x * mean_x + mean_y * mean_y + mean_z * mean_z;
        thr2 = longint'(threshold_reg) * longint'(threshold_reg);
        if (mag2 > thr2) begin
            // A gain of zero behaves as a gain of one.
            gain = (gain_reg == '0) ? longint'(1) : longint'(gain_reg);
            cmd.vel_x = OUT_W'(clamp_velocity((mean_x * 256) / gain));
            cmd.vel_y = OUT_W'(clamp_velocity(-((mean_y * 256) / gain)));
            cmd.vel_z = OUT_W'(clamp_velocity(-((mean_z * 256) / gain)));
        end else begin
            cmd.vel_x = '0;
            cmd.vel_y = '0;
            cmd.vel_z = '0;
        end
        abs_torque = longint'(tz);
        if (abs_torque < 0) abs_torque = -abs_torque;
        cmd.capture = (abs_torque > longint'(torque_reg));
        expected_velocities = {expected_velocities, cmd};
    endfunction

    function automatic void check_field(input string field, input logic [OUT_W-1:0] want,
                                        input logic [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, $signed(want), $signed(got));
            mismatch_count++;
        end
    endfunction

    // Every accepted velocity item is compared with the oldest prediction.
    always @(posedge aclk) begin : result_check
        velocity_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_velocities.size() == 0) begin
                $error("velocity item with none expected: vel_x %0d", m_vel_x);
                mismatch_count++;
            end else begin
                want = expected_velocities.pop_front();
                check_field("vel_x", want.vel_x, m_vel_x);
                check_field("vel_y", want.vel_y, m_vel_y);
                check_field("vel_z", want.vel_z, m_vel_z);
                check_field("capture", OUT_W'(want.capture), OUT_W'(m_capture));
            end
        end
    end

    // Offers one sample, after a random gap unless idling is off, and returns at
    // the edge that accepts it. Valid stays high when the next item follows at once.
    task automatic send_sample(input int fx, input int fy, input int fz, input int tz);
        while (!no_idle && $urandom_range(0, 99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_force_x  <= IN_W'(fx);
        s_force_y  <= IN_W'(fy);
        s_force_z  <= IN_W'(fz);
        s_torque_z <= IN_W'(tz);
        do @(posedge aclk); while (!s_ready);
        predict_velocity(IN_W'(fx), IN_W'(fy), IN_W'(fz), IN_W'(tz));
    endtask

    task automatic write_register(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_FORCE_THRESHOLD: threshold_reg = data[THR_W-1:0];
            REG_GAIN_DIVISOR:    gain_reg      = data[GAIN_W-1:0];
            REG_TORQUE_LIMIT:    torque_reg    = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all three registers back to back and, if asked, the unused index too.
    task automatic program_registers(input logic [CFG_W-1:0] thr_data, gain_data, torque_data,
                                     input bit touch_spare);
        write_register(REG_FORCE_THRESHOLD, thr_data);
        write_register(REG_GAIN_DIVISOR, gain_data);
        write_register(REG_TORQUE_LIMIT, torque_data);
        if (touch_spare) write_register(REG_SPARE, CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Waits for every predicted item, then for the block's latency, since a sample
    // that only fills the ring can still be in flight.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (expected_velocities.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // A force value: full range, small, near the phase's center, or an extreme.
    function automatic int random_force(input int center);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return int'($signed(IN_W'($urandom)));
        else if (pick < 50) return int'($urandom_range(0, 4000)) - 2000;
        else if (pick < 90) return center + int'($urandom_range(0, 2000)) - 1000;
        else if (pick < 95) return FORCE_MIN;
        else return FORCE_MAX;
    endfunction

    // A torque value: full range half of the time, otherwise just around the limit.
    function automatic int random_torque();
        int level;
        if ($urandom_range(0, 1) == 0) return int'($signed(IN_W'($urandom)));
        level = int'(torque_reg) + int'($urandom_range(0, 2)) - 1;
        if (level > FORCE_MAX) level = FORCE_MAX;
        return ($urandom_range(0, 1) == 0) ? level : -level;
    endfunction

    // Fills the ring with extreme forces while the torque swings between its extremes
    // (it must be ignored), checks the first item under the reset register values,
    // then drives the y and z velocities past their positive limit with a gain of one.
    task automatic test_fill_and_saturation();
        int i;
        for (i = 0; i < WINDOW; i++) begin
            send_sample(FORCE_MAX, FORCE_MIN, FORCE_MIN, (i % 2 == 1) ? FORCE_MAX : FORCE_MIN);
        end
        send_sample(FORCE_MAX, FORCE_MIN, FORCE_MIN, FORCE_MIN);
        wait_until_drained();
        program_registers(CFG_MAX, CFG_W'(1), CFG_MAX, 1'b0);
        // With the largest torque limit only the most negative torque captures.
        send_sample(FORCE_MAX, FORCE_MIN, FORCE_MIN, FORCE_MIN);
        send_sample(FORCE_MAX, FORCE_MIN, FORCE_MIN, FORCE_MAX);
        send_sample(FORCE_MAX, FORCE_MIN, FORCE_MIN, 0);
        wait_until_drained();
    endtask

    // A window of identical samples puts the mean magnitude exactly on the deadband,
    // which must give zero velocity; one larger sample lifts the mean just above it.
    // The gain write carries only upper bits, so the masked gain is zero.
    task automatic test_deadband_edge();
        logic [CFG_W-1:0] gain_data;
        int               i;
        gain_data = CFG_MAX;
        gain_data[GAIN_W-1:0] = '0;
        program_registers(CFG_W'(1280), gain_data, '0, 1'b1);
        for (i = 0; i < WINDOW; i++) begin
            send_sample(1280, 0, 0, (i % 3 == 0) ? 0 : ((i % 3 == 1) ? 1 : -1));
        end
        send_sample(1300, 0, 0, 0);
        wait_until_drained();
    endtask

    // The receiver holds off for a long stretch while samples keep coming, so the
    // block fills up and has to drop its input ready.
    task automatic test_output_backpressure();
        int i;
        no_idle = 1'b1;
        stall_cycles = 400;
        for (i = 0; i < 40; i++) begin
            send_sample(random_force(0), random_force(0), random_force(0), random_torque());
        end
        wait_until_drained();
        no_idle = 1'b0;
    endtask

    // Random samples under a series of register settings, the extremes among them.
    // One phase runs with no idling on either side.
    task automatic test_random_phases();
        logic [CFG_W-1:0] thr_data, gain_data, torque_data;
        int               phase, cx, cy, cz;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0:       thr_data = '0;
                1:       thr_data = CFG_MAX;
                2:       thr_data = CFG_W'($urandom_range(0, 3000));
                default: thr_data = CFG_W'($urandom);
            endcase
            // Upper data bits are random; only the low gain bits may take effect.
            gain_data = CFG_W'($urandom);
            case ((phase + 1) % 4)
                0:       gain_data[GAIN_W-1:0] = GAIN_W'(1);
                1:       gain_data[GAIN_W-1:0] = '1;
                2:       gain_data[GAIN_W-1:0] = '0;
                default: gain_data[GAIN_W-1:0] = GAIN_W'($urandom_range(1, 1023));
            endcase
            case ((phase + 2) % 3)
                0:       torque_data = '0;
                1:       torque_data = CFG_MAX;
                default: torque_data = CFG_W'($urandom_range(0, 4000));
            endcase
            cx = int'($urandom_range(0, 1040000)) - 520000;
            cy = int'($urandom_range(0, 1040000)) - 520000;
            cz = int'($urandom_range(0, 1040000)) - 520000;
            no_idle = (phase == 5);
            program_registers(thr_data, gain_data, torque_data, phase % 2 == 1);
            repeat (ITEMS_PER_PHASE) begin
                send_sample(random_force(cx), random_force(cy), random_force(cz),
                            random_torque());
            end
            wait_until_drained();
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_fill_and_saturation();
        test_deadband_edge();
        test_output_backpressure();
        test_random_phases();
        // Catch any stray item that shows up after the last expected one.
        repeat (LATENCY) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
